/* hw/rtl/key_hash_word_stream_defines.svh */
// ----------------------------------------------------------------------------
// Key hash word stream: assertion macros
// Shared concurrent assertion forms, clocked by aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_HASH_WORD_STREAM_DEFINES_SVH
`define KEY_HASH_WORD_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KHWS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("key hash word stream: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KHWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("key hash word stream: next-cycle check failed");

`endif

/* hw/rtl/khws_pkg.sv */
// ----------------------------------------------------------------------------
// Key hash word stream package
// Widths, hash constants and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package khws_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned S_TDATA_W = 72;   // 32 + 3 + 32 = 67, padded to bytes
    localparam int unsigned M_TDATA_W = 32;

    // Field positions inside s_tdata.
    localparam int unsigned WORD_LSB  = 0;
    localparam int unsigned COUNT_LSB = 32;
    localparam int unsigned KLEN_LSB  = 35;

    localparam logic [WORD_W-1:0]  MIX_MUL    = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0]  FIN_MUL    = 32'h85ebca6b;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;    // capture the input word and seed the running hash
        logic mul_mix;    // multiply (hash + lane) by the mixing constant
        logic rotate;     // write back the rotated product, advance the lane
        logic fin_one;    // first finalizer multiply
        logic fin_two;    // second finalizer multiply
        logic load_out;   // load the result register
    } khws_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_no_mix;  // incoming word carries no bytes
        logic in_last;    // incoming word ends the key
        logic mix_done;   // the lane being mixed is the final one
        logic last;       // captured word ends the key
        logic out_free;   // result register can take a new value
    } khws_status_t;

endpackage

/* hw/rtl/key_hash_word_stream.sv */
// ----------------------------------------------------------------------------
// Key hash word stream
// Murmur-style 32-bit hash of a key delivered as little-endian 32-bit words.
//
//   Channel | Direction | tdata fields (low bit up)                 | tuser      | tlast
//   s_      | in        | data_word, byte_count, key_length, zeros  | first_item | last_item
//   m_      | out       | hash_value                                | -          | -
//
// One word at a time. A full word passes capture, multiply and rotate; a
// partial word is captured, then multiplied and rotated once per byte. A
// word that ends the key then runs the finalizer on the single shared 32-bit
// multiplier and its product register. The result register holds the hash
// until it is taken, and the block keeps accepting words meanwhile; only a
// second finalized hash waits for the first to leave. Reset is synchronous,
// active low, clears the running hash and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "key_hash_word_stream_defines.svh"

module key_hash_word_stream (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_word[31:0], byte_count[34:32], key_length[66:35], zero fill
    input  logic [khws_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    // first_item
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hash_value[31:0]
    output logic [khws_pkg::M_TDATA_W-1:0] m_tdata
);
    import khws_pkg::*;

    khws_cmd_t    cmd;
    khws_status_t status;

    // Sequencer.
    khws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hash datapath.
    khws_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A finalized hash never overwrites one that is still waiting.
    `KHWS_ASSERT_SAME(a_no_overwrite, cmd.load_out, status.out_free)
    // A word that ends the key always keeps the input closed in the next cycle.
    `KHWS_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready)
    // A new result appears only after the controller loaded it.
    `KHWS_ASSERT_SAME(a_out_source, $rose(m_tvalid), $past(cmd.load_out))

endmodule

/* hw/rtl/khws_ctrl.sv */
// ----------------------------------------------------------------------------
// Key hash word stream controller
// Sequences the capture, the mixing steps and the finalizer for one word.
// ----------------------------------------------------------------------------
module khws_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  khws_pkg::khws_status_t status,
    output khws_pkg::khws_cmd_t    cmd
);
    import khws_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_FIN1 = 3'd3;
    localparam logic [2:0] ST_FIN2 = 3'd4;
    localparam logic [2:0] ST_FIN3 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (!status.in_no_mix) begin
                        state_next = ST_MUL;
                    end else if (status.in_last) begin
                        state_next = ST_FIN1;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_mix = 1'b1;
                state_next  = ST_ROT;
            end
            ST_ROT: begin
                cmd.rotate = 1'b1;
                if (!status.mix_done) begin
                    state_next = ST_MUL;
                end else if (status.last) begin
                    state_next = ST_FIN1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN1: begin
                cmd.fin_one = 1'b1;
                state_next  = ST_FIN2;
            end
            ST_FIN2: begin
                cmd.fin_two = 1'b1;
                state_next  = ST_FIN3;
            end
            ST_FIN3: begin
                // Wait here until the previous result has been taken.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/khws_dp.sv */
// ----------------------------------------------------------------------------
// Key hash word stream datapath
// Running hash, captured word, one shared 32-bit multiplier and the result
// register.
// ----------------------------------------------------------------------------
module khws_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [khws_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tuser,
    input  khws_pkg::khws_cmd_t               cmd,
    output khws_pkg::khws_status_t            status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [khws_pkg::M_TDATA_W-1:0]    m_tdata
);
    import khws_pkg::*;

    logic [WORD_W-1:0]  in_word;
    logic [COUNT_W-1:0] in_count;
    logic [WORD_W-1:0]  in_klen;

    logic [WORD_W-1:0]  hash_reg;
    logic [WORD_W-1:0]  hash_next;
    logic [WORD_W-1:0]  word_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WORD_W-1:0]  prod_reg;
    logic [WORD_W-1:0]  out_reg;
    logic               out_valid_reg;

    logic               full_word;
    logic [WORD_W-1:0]  lane_val;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [2*WORD_W-1:0] mul_full;
    logic [COUNT_W-1:0] idx_plus;

    // Unpack the input fields.
    assign in_word  = s_tdata[WORD_LSB  +: WORD_W];
    assign in_count = s_tdata[COUNT_LSB +: COUNT_W];
    assign in_klen  = s_tdata[KLEN_LSB  +: WORD_W];

    // Lane to be mixed: the whole word, or one byte of it.
    assign full_word = (count_reg == FULL_COUNT);
    assign lane_val  = full_word ? word_reg
                                 : {24'd0, word_reg[{idx_reg, 3'b000} +: 8]};
    assign idx_plus  = {1'b0, idx_reg} + 3'd1;

    // Shared multiplier operands.
    always_comb begin
        mul_a = hash_reg + lane_val;
        mul_b = MIX_MUL;
        if (cmd.fin_one) begin
            mul_a = hash_reg ^ (hash_reg >> 16);
            mul_b = FIN_MUL;
        end else if (cmd.fin_two) begin
            mul_a = prod_reg ^ (prod_reg >> 13);
            mul_b = MIX_MUL;
        end
    end

    assign mul_full = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};

    // Running hash: seed on capture, rotate-left-13 write back after a mix.
    always_comb begin
        hash_next = hash_reg;
        if (cmd.load_in) begin
            hash_next = s_tuser ? in_klen : hash_reg;
        end else if (cmd.rotate) begin
            hash_next = {prod_reg[18:0], prod_reg[31:19]};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            word_reg  <= in_word;
            count_reg <= (in_count >= FULL_COUNT) ? FULL_COUNT : in_count;
            last_reg  <= s_tlast;
            idx_reg   <= '0;
        end else if (cmd.rotate) begin
            idx_reg <= idx_plus[IDX_W-1:0];
        end
        if (cmd.mul_mix || cmd.fin_one || cmd.fin_two) begin
            prod_reg <= mul_full[WORD_W-1:0];
        end
        if (cmd.load_out) begin
            out_reg <= prod_reg ^ (prod_reg >> 16);
        end
    end

    // Status back to the controller.
    assign status.in_no_mix = (in_count == '0);
    assign status.in_last   = s_tlast;
    assign status.mix_done  = full_word || (idx_plus == count_reg);
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
